[design/baro_pressure_compensation_unit_macros.svh]
// assertion helpers for the compensation unit
`ifndef BARO_PRESSURE_COMPENSATION_UNIT_MACROS_SVH
`define BARO_PRESSURE_COMPENSATION_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bpc_pkg.sv]
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [7:0]  press_msb;
    logic [7:0]  press_lsb;
    logic [7:0]  press_xlsb;
  } bpc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_decideg;
    logic signed [31:0] pressure_pa;
    logic signed [31:0] reference_pa;
    logic               divide_error;
  } bpc_out_t;

  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_M = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] P_COEF_A  = 32'd3038;
  localparam logic [31:0] P_COEF_B  = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_COEF_C  = 32'd3791;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;

  // sequencer steps; each multiply step uses the shared multiplier once
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL,     // x1 = asr((ut-ac6)*ac5,15)
    ST_T_DIV,     // start x2 divide
    ST_T_DWAIT,
    ST_B6SQ,      // sq = asr(b6*b6,12)
    ST_B2SQ,      // x1 = asr(b2*sq,11)
    ST_AC2B6,     // x2 = asr(ac2*b6,11), b3
    ST_AC3B6,     // x1 = asr(ac3*b6,13)
    ST_B1SQ,      // x2 = asr(b1*sq,16), x3
    ST_B4MUL,     // b4
    ST_B7MUL,     // b7
    ST_P_DIV,
    ST_P_DWAIT,
    ST_PSQ,       // (p>>8)^2
    ST_PC1,       // *3038
    ST_PC2,       // -7357*p
    ST_FINISH,
    ST_OUT
  } bpc_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } bpc_div_req_t;

endpackage

[design/bpc_divider.sv]
module bpc_divider
  import bpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  bpc_div_req_t req,
  output logic         busy,
  output logic [31:0]  quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      count <= 6'd32;
    end else if (count != 6'd0) begin
      count <= count - 6'd1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (count != 6'd0) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign busy     = (count != 6'd0);
  assign quotient = quo;

endmodule

[design/baro_pressure_compensation_unit.sv]
// Barometric sensor compensation: takes one raw temperature word and three raw
// pressure bytes per transaction and returns temperature in 0.1 degC, pressure in
// pascals, the latched reference pressure and a divide error flag. All math is
// the 32-bit wraparound integer datasheet algorithm, run by a sequencer over one
// shared 32x32 multiplier and one restoring divider that yields a bit a cycle.
// For each item the sequencer runs eleven multiply steps and two divides, each
// divide launched from its own step, then a finish step and an output step. A
// zero temperature divisor skips from its launch step straight to the finish
// step, as does a zero pressure divisor. in_stall is high from the cycle after
// acceptance until the result is taken, so a new item is accepted only after
// the previous result is taken. Calibration registers must be written through
// cfg_we/cfg_index/cfg_data only while the unit is idle, which it does not enforce.
module baro_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  bpc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output bpc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

`include "baro_pressure_compensation_unit_macros.svh"

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss;

  bpc_state_t state, state_next;

  // working registers
  logic [31:0] ut, up, x1, b5, b6, sq, acc, b3, b4, b7, p;
  logic        err;
  logic [31:0] last_pressure, reference_pressure;

  // calibration fields
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_a[15]}}, cal_a[15:0]};
  assign ac2 = {{16{cal_a[31]}}, cal_a[31:16]};
  assign ac3 = {{16{cal_a[47]}}, cal_a[47:32]};
  assign ac4 = {16'd0, cal_a[63:48]};
  assign ac5 = {16'd0, cal_b[15:0]};
  assign ac6 = {16'd0, cal_b[31:16]};
  assign b1  = {{16{cal_b[47]}}, cal_b[47:32]};
  assign b2  = {{16{cal_b[63]}}, cal_b[63:48]};
  assign mc  = {{16{cal_m[15]}}, cal_m[15:0]};
  assign md  = {{16{cal_m[31]}}, cal_m[31:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_m <= '0;
      oss   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_A: cal_a <= cfg_data;
        REG_CAL_B: cal_b <= cfg_data;
        REG_CAL_M: cal_m <= cfg_data[31:0];
        REG_OSS:   oss   <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  // shared multiplier operand selection, low 32 bits kept
  logic [31:0] mul_a, mul_b, mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_T_MUL: begin mul_a = ut - ac6;            mul_b = ac5; end
      ST_B6SQ:  begin mul_a = b6;                  mul_b = b6; end
      ST_B2SQ:  begin mul_a = b2;                  mul_b = sq; end
      ST_AC2B6: begin mul_a = ac2;                 mul_b = b6; end
      ST_AC3B6: begin mul_a = ac3;                 mul_b = b6; end
      ST_B1SQ:  begin mul_a = b1;                  mul_b = sq; end
      ST_B4MUL: begin mul_a = ac4;                 mul_b = acc + B4_BIAS; end
      ST_B7MUL: begin mul_a = up - b3;             mul_b = B7_SCALE >> oss; end
      ST_PSQ:   begin mul_a = $signed(p) >>> 8;    mul_b = $signed(p) >>> 8; end
      ST_PC1:   begin mul_a = acc;                 mul_b = P_COEF_A; end
      ST_PC2:   begin mul_a = P_COEF_B;            mul_b = p; end
      default:  ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider with sign handling around it
  bpc_div_req_t div_req;
  logic         div_busy;
  logic [31:0]  div_q;
  logic [31:0]  tdiv, tnum;
  logic         tneg;
  assign tdiv = x1 + md;
  assign tnum = mc << 11;
  assign tneg = tnum[31] ^ tdiv[31];

  always_comb begin
    div_req = '0;
    case (state)
      ST_T_DIV: begin
        div_req.start    = (tdiv != 32'd0);
        div_req.dividend = tnum[31] ? 32'd0 - tnum : tnum;
        div_req.divisor  = tdiv[31] ? 32'd0 - tdiv : tdiv;
      end
      ST_P_DIV: begin
        div_req.start    = (b4 != 32'd0);
        div_req.dividend = (b7 < SIGN_BIT) ? (b7 << 1) : b7;
        div_req.divisor  = b4;
      end
      default: ;
    endcase
  end

  bpc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  logic        b7_big;
  logic [31:0] x2t, b5_new, b3_pre, t_raw;
  assign b7_big = (b7 >= SIGN_BIT);
  assign x2t    = tneg ? 32'd0 - div_q : div_q;
  assign b5_new = x1 + x2t;
  assign b3_pre = ((ac1 << 2) + acc + $unsigned($signed(mul_p) >>> 11)) << oss;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_T_MUL;
      ST_T_MUL:   state_next = ST_T_DIV;
      ST_T_DIV:   state_next = (tdiv == 32'd0) ? ST_FINISH : ST_T_DWAIT;
      ST_T_DWAIT: if (!div_busy) state_next = ST_B6SQ;
      ST_B6SQ:    state_next = ST_B2SQ;
      ST_B2SQ:    state_next = ST_AC2B6;
      ST_AC2B6:   state_next = ST_AC3B6;
      ST_AC3B6:   state_next = ST_B1SQ;
      ST_B1SQ:    state_next = ST_B4MUL;
      ST_B4MUL:   state_next = ST_B7MUL;
      ST_B7MUL:   state_next = ST_P_DIV;
      ST_P_DIV:   state_next = (b4 == 32'd0) ? ST_FINISH : ST_P_DWAIT;
      ST_P_DWAIT: if (!div_busy) state_next = ST_PSQ;
      ST_PSQ:     state_next = ST_PC1;
      ST_PC1:     state_next = ST_PC2;
      ST_PC2:     state_next = ST_FINISH;
      ST_FINISH:  state_next = ST_OUT;
      ST_OUT:     if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ut  <= {16'd0, in_data.raw_temperature};
        up  <= {8'd0, in_data.press_msb, in_data.press_lsb, in_data.press_xlsb}
               >> (4'd8 - {2'd0, oss});
        err <= 1'b0;
        p   <= '0;
      end
      ST_T_MUL: x1 <= $signed(mul_p) >>> 15;
      ST_T_DIV: if (tdiv == 32'd0) begin
        err <= 1'b1;
        b5  <= x1;
      end
      ST_T_DWAIT: if (!div_busy) begin
        b5 <= b5_new;
        b6 <= b5_new - B6_OFFSET;
      end
      ST_B6SQ:  sq  <= $signed(mul_p) >>> 12;
      ST_B2SQ:  acc <= $signed(mul_p) >>> 11;
      ST_AC2B6: b3  <= $signed(b3_pre + 32'd2) >>> 2;
      ST_AC3B6: acc <= $signed(mul_p) >>> 13;
      ST_B1SQ:  acc <= $signed(acc + $unsigned($signed(mul_p) >>> 16) + 32'd2) >>> 2;
      ST_B4MUL: b4  <= mul_p >> 15;
      ST_B7MUL: b7  <= mul_p;
      ST_P_DIV: if (b4 == 32'd0) err <= 1'b1;
      ST_P_DWAIT: if (!div_busy) p <= b7_big ? (div_q << 1) : div_q;
      ST_PSQ:   acc <= mul_p;
      ST_PC1:   acc <= $signed(mul_p) >>> 16;
      ST_PC2:   p   <= p + $unsigned($signed(acc + $unsigned($signed(mul_p) >>> 16)
                                             + P_COEF_C) >>> 4);
      default:  ;
    endcase
  end

  // reference latch while last pressure is zero
  logic [31:0] p_final;
  assign p_final = err ? 32'd0 : p;
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure      <= '0;
      reference_pressure <= '0;
    end else if (state == ST_FINISH) begin
      if (last_pressure == 32'd0) reference_pressure <= p_final;
      last_pressure <= p_final;
    end
  end

  // temperature with saturation
  logic signed [31:0] t_s;
  assign t_raw = $signed(b5 + 32'd8) >>> 4;
  assign t_s   = $signed(t_raw);
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      if (t_s > 32'sd32767)       out_data.temperature_decideg <= 16'sh7FFF;
      else if (t_s < -32'sd32768) out_data.temperature_decideg <= 16'sh8000;
      else                        out_data.temperature_decideg <= t_raw[15:0];
      out_data.pressure_pa  <= p_final;
      out_data.divide_error <= err;
      out_data.reference_pa <= (last_pressure == 32'd0) ? p_final
                                                        : reference_pressure;
    end
  end

  assign out_valid = (state == ST_OUT);
  assign in_stall  = (state != ST_IDLE);

  `BPC_ASSERT_IMP(a_err_zero, out_valid && out_data.divide_error,
                  out_data.pressure_pa == 32'sd0, "error result with nonzero pressure")
  `BPC_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall,
                   state == ST_T_MUL, "accepted transaction did not start")
  `BPC_ASSERT_IMP(a_no_div_out, out_valid, !div_busy, "result while divider busy")

endmodule

[dv/baro_pressure_compensation_unit_checker.sv]
module baro_pressure_compensation_unit_checker
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  bpc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  bpc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss;
  logic [31:0] last_p, ref_p;
  bpc_out_t    expected_q[$];

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic bpc_out_t compensate(bpc_in_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, dv, t;
    logic err;
    bpc_out_t r;
    ac1 = sx16(cal_a[15:0]);  ac2 = sx16(cal_a[31:16]);
    ac3 = sx16(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
    ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
    b1 = sx16(cal_b[47:32]);  b2 = sx16(cal_b[63:48]);
    mc = sx16(cal_m[15:0]);   md = sx16(cal_m[31:16]);
    ut = {16'd0, s.raw_temperature};
    up = {8'd0, s.press_msb, s.press_lsb, s.press_xlsb} >> (8 - oss);
    err = 1'b0;
    p = '0;
    x1 = asr((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) begin
      err = 1'b1;
      x2 = '0;
    end else begin
      x2 = sdiv(mc << 11, dv);
    end
    b5 = x1 + x2;
    if (!err) begin
      b6 = b5 - B6_OFFSET;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = ((ac1 << 2) + x3) << oss;
      b3 = asr(b3 + 2, 2);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 2, 2);
      b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
      b7 = (up - b3) * (B7_SCALE >> oss);
      if (b4 == 0) begin
        err = 1'b1;
      end else begin
        if (b7 < SIGN_BIT) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * P_COEF_A, 16);
        x2 = asr(P_COEF_B * p, 16);
        p = p + asr(x1 + x2 + P_COEF_C, 4);
      end
    end
    if (err) p = '0;
    if (last_p == 0) ref_p = p;
    last_p = p;
    t = asr(b5 + 8, 4);
    if ($signed(t) > 32767) t = 32'd32767;
    if ($signed(t) < -32768) t = 32'hFFFF_8000;
    r.temperature_decideg = t[15:0];
    r.pressure_pa = p;
    r.reference_pa = ref_p;
    r.divide_error = err;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    bpc_out_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      cal_a <= '0; cal_b <= '0; cal_m <= '0; oss <= '0;
      last_p = '0; ref_p = '0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_A: cal_a <= cfg_data;
          REG_CAL_B: cal_b <= cfg_data;
          REG_CAL_M: cal_m <= cfg_data[31:0];
          REG_OSS:   oss <= cfg_data[1:0];
          default:   ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", out_data);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (want.temperature_decideg !== out_data.temperature_decideg) begin
            $error("temperature_decideg exp %0d got %0d", want.temperature_decideg,
                   out_data.temperature_decideg);
            errs++;
          end
          if (want.pressure_pa !== out_data.pressure_pa) begin
            $error("pressure_pa exp %0d got %0d", want.pressure_pa, out_data.pressure_pa);
            errs++;
          end
          if (want.reference_pa !== out_data.reference_pa) begin
            $error("reference_pa exp %0d got %0d", want.reference_pa,
                   out_data.reference_pa);
            errs++;
          end
          if (want.divide_error !== out_data.divide_error) begin
            $error("divide_error exp %0b got %0b", want.divide_error,
                   out_data.divide_error);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(compensate(in_data));
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

[dv/baro_pressure_compensation_unit_test.sv]
module baro_pressure_compensation_unit_test;
  import bpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bpc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bpc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_CAL_A;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;   // long receiver hold-off request
  bit          stim_done = 1'b0;

  localparam int WATCHDOG = 20000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  baro_pressure_compensation_unit dut (.*);

  baro_pressure_compensation_unit_checker checker_i (.*);

  // calibration set modeled on typical sensor values
  localparam logic [63:0] TYP_A = {16'd32741, 16'hFE37, 16'hC7D1, 16'h0198};
  localparam logic [63:0] TYP_B = {16'h8000, 16'd4, 16'd23153, 16'd32757} ;
  localparam logic [31:0] TYP_M = {16'd2868, 16'hD4BD};

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the unit has drained all outstanding transactions
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // present one transaction and hold it until accepted
  task automatic send_sample(bpc_in_t s);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_random(int count, bit typical);
    bpc_in_t s;
    int burst;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        s = 40'({$urandom, $urandom});
        // mostly plausible raw readings, sometimes anything
        if (typical && $urandom_range(0, 3) != 0) begin
          s.raw_temperature = 16'($urandom_range(20000, 32000));
          s.press_msb = 8'($urandom_range(8'h90, 8'hB0));
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stim_done || $urandom_range(0, 9) < 6) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // watchdog: cycles without any input or output handshake, reset or configuration write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero calibration: temperature divisor zero case
    send_sample('0);
    send_sample({16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
    drain();

    cfg_write(REG_CAL_A, TYP_A);
    cfg_write(REG_CAL_B, TYP_B);
    cfg_write(REG_CAL_M, {32'd0, TYP_M});
    cfg_write(REG_OSS, 64'd0);
    // first nonzero pressure latches the reference
    send_sample({16'd27898, 8'h9D, 8'h4C, 8'h00});
    send_sample({16'd27000, 8'hA0, 8'h00, 8'h00});
    send_sample({16'd0, 8'h00, 8'h00, 8'h00});
    send_sample({16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
    drain();

    // ac4 zero gives pressure divisor zero
    cfg_write(REG_CAL_A, {16'd0, TYP_A[47:0]});
    send_sample({16'd27898, 8'h9D, 8'h4C, 8'h00});
    drain();
    // large b7 through an extreme b3
    cfg_write(REG_CAL_A, {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    cfg_write(REG_OSS, 64'd3);
    send_sample({16'd27898, 8'h00, 8'h00, 8'h00});
    send_sample({16'd27898, 8'hFF, 8'hFF, 8'hFF});
    drain();
    cfg_write(REG_CAL_A, '1);
    cfg_write(REG_CAL_B, '1);
    cfg_write(REG_CAL_M, '1);
    send_sample({16'h8000, 8'h80, 8'h80, 8'h80});
    send_sample({16'h7FFF, 8'h7F, 8'h7F, 8'h7F});
    drain();

    // random phases through several oversampling and calibration settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        cfg_write(REG_CAL_A, TYP_A ^ {48'd0, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))});
        cfg_write(REG_CAL_B, TYP_B);
        cfg_write(REG_CAL_M, {32'd0, TYP_M});
      end else begin
        cfg_write(REG_CAL_A, {$urandom, $urandom});
        cfg_write(REG_CAL_B, {$urandom, $urandom});
        cfg_write(REG_CAL_M, {32'd0, $urandom});
      end
      cfg_write(REG_OSS, {62'd0, ph[1:0]});
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_off <= 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
          send_random(10, 1'b1);
        join
      end
      send_random(ph < 4 ? 200 : 120, ph < 4);
      drain();
    end

    stim_done <= 1'b1;
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
